// ===== hdl/i2c_register_access_master_defines.svh =====
// assertion macros for the i2c register access master
`ifndef I2C_REGISTER_ACCESS_MASTER_DEFINES_SVH
`define I2C_REGISTER_ACCESS_MASTER_DEFINES_SVH
// consequent holds in the cycle after the trigger
`define IRAM_ASSERT_NEXT(label, clk, rst_n, trig, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cons)) \
        else $error("%m: check failed");
// consequent holds in the same cycle as the trigger
`define IRAM_ASSERT_SAME(label, clk, rst_n, trig, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cons)) \
        else $error("%m: check failed");
`endif

// ===== hdl/iram_pkg.sv =====
// shared types and constants for the i2c register access master
`default_nettype none
package iram_pkg;
    localparam logic [1:0] FUNC_TICK  = 2'd0;
    localparam logic [1:0] FUNC_BEGIN = 2'd1;
    localparam logic [1:0] FUNC_WBYTE = 2'd2;

    localparam logic [1:0] CFG_DATA_PHASE = 2'd0;
    localparam logic [1:0] CFG_CTRL_PHASE = 2'd1;
    localparam logic [1:0] CFG_ACK_TMO    = 2'd2;

    localparam logic [1:0] STATUS_OK      = 2'd0;
    localparam logic [1:0] STATUS_NO_ACK  = 2'd1;
    localparam logic [1:0] STATUS_BUS_ERR = 2'd2;

    localparam logic [15:0] DATA_PHASE_RST = 16'd50;
    localparam logic [15:0] CTRL_PHASE_RST = 16'd5;
    localparam logic [19:0] ACK_TMO_RST    = 20'hFFFF0;

    typedef struct packed {
        logic [1:0]  func;
        logic [7:0]  dev_addr;
        logic [15:0] reg_addr;
        logic        reg_wide;
        logic        is_read;
        logic [7:0]  xfer_length;
        logic [7:0]  wr_data;
        logic        sda_in;
    } in_item_t;

    typedef struct packed {
        logic        scl_out;
        logic        sda_out;
        logic        rd_valid;
        logic [7:0]  rd_data;
        logic        rd_last;
        logic        wr_request;
        logic        busy_res;
        logic        done_res;
        logic [1:0]  status;
    } out_item_t;

    typedef struct packed {
        logic [15:0] data_phase_ticks;
        logic [15:0] ctrl_phase_ticks;
        logic [19:0] ack_timeout;
    } cfg_t;
endpackage
`default_nettype wire

// ===== hdl/iram_front.sv =====
// two-entry input queue between the command front and the bus engine
`default_nettype none
module iram_front (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire iram_pkg::in_item_t s_data,
    output logic                    q_valid,
    input  wire logic               q_ready,
    output iram_pkg::in_item_t      q_data
);
    // two-entry queue
    iram_pkg::in_item_t mem_reg [2];
    logic       wr_ptr_reg, wr_ptr_next, rd_ptr_reg, rd_ptr_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       push, pop;

    assign s_ready = (cnt_reg != 2'd2);
    assign q_valid = (cnt_reg != 2'd0);
    assign q_data  = mem_reg[rd_ptr_reg];
    assign push    = s_valid && s_ready;
    assign pop     = q_valid && q_ready;

    always_comb begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= s_data;
        end
    end
endmodule
`default_nettype wire

// ===== hdl/iram_engine.sv =====
// bus sequencer: one queued item per cycle while the skid entry is free, result into an output skid buffer
`default_nettype none
module iram_engine (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire iram_pkg::cfg_t      cfg,
    input  wire logic                q_valid,
    output logic                     q_ready,
    input  wire iram_pkg::in_item_t  q_data,
    output logic                     m_valid,
    input  wire logic                m_ready,
    output iram_pkg::out_item_t      m_data
);
    localparam logic [3:0] ST_IDLE = 4'd0, ST_START_HI = 4'd1, ST_START_LO = 4'd2,
        ST_TX_SETUP = 4'd3, ST_TX_HIGH = 4'd4, ST_TX_LOW = 4'd5, ST_SLV_REL = 4'd6,
        ST_SLV_CLK = 4'd7, ST_SLV_POLL = 4'd8, ST_WR_WAIT = 4'd9, ST_RX_LOW = 4'd10,
        ST_RX_HIGH = 4'd11, ST_MA_LOW = 4'd12, ST_MA_HIGH = 4'd13,
        ST_STOP_LO = 4'd14, ST_STOP_HI = 4'd15;
    localparam logic [2:0] ROLE_ADDR_W = 3'd0, ROLE_REG_HI = 3'd1, ROLE_REG_LO = 3'd2,
        ROLE_DATA = 3'd3, ROLE_ADDR_R = 3'd4;

    logic [3:0]  st_reg, st_next;
    logic [15:0] pcnt_reg, pcnt_next;
    logic [3:0]  bit_reg, bit_next;
    logic [7:0]  shf_reg, shf_next;
    logic [7:0]  left_reg, left_next;
    logic [19:0] ackw_reg, ackw_next;
    logic [7:0]  dev_reg, dev_next;
    logic [15:0] rega_reg, rega_next;
    logic        wide_reg, wide_next, rd_reg, rd_next;
    logic [8:0]  held_reg, held_next;
    logic [2:0]  role_reg, role_next;
    logic [1:0]  ends_reg, ends_next;

    // output register plus skid entry
    iram_pkg::out_item_t o0_reg, o1_reg, res;
    logic v0_reg, v1_reg;
    logic step;
    logic [15:0] plen;
    logic [15:0] pinc;
    logic [3:0]  binc;
    logic        m_bit;

    assign q_ready = !v1_reg;
    assign step    = q_valid && q_ready;
    assign m_valid = v0_reg;
    assign m_data  = o0_reg;

    always_comb begin
        unique case (st_reg)
            ST_START_HI, ST_START_LO, ST_MA_LOW, ST_MA_HIGH, ST_STOP_LO, ST_STOP_HI:
                plen = cfg.ctrl_phase_ticks;
            ST_TX_SETUP, ST_TX_HIGH, ST_TX_LOW, ST_RX_LOW, ST_RX_HIGH:
                plen = cfg.data_phase_ticks;
            default: plen = 16'd1;
        endcase
    end

    always_comb begin
        st_next = st_reg; pcnt_next = pcnt_reg; bit_next = bit_reg;
        shf_next = shf_reg; left_next = left_reg; ackw_next = ackw_reg;
        dev_next = dev_reg; rega_next = rega_reg; wide_next = wide_reg;
        rd_next = rd_reg; held_next = held_reg; role_next = role_reg;
        ends_next = ends_reg;
        res = '0;
        pinc = pcnt_reg + 16'd1;
        binc = bit_reg + 4'd1;
        unique case (q_data.func)
            iram_pkg::FUNC_BEGIN: begin
                if (st_reg == ST_IDLE) begin
                    dev_next = q_data.dev_addr; rega_next = q_data.reg_addr;
                    wide_next = q_data.reg_wide; rd_next = q_data.is_read;
                    left_next = (q_data.is_read && q_data.xfer_length == 8'd0)
                        ? 8'd1 : q_data.xfer_length;
                    held_next = '0; ends_next = iram_pkg::STATUS_OK;
                    role_next = ROLE_ADDR_W;
                    st_next = ST_START_HI; pcnt_next = '0;
                end
            end
            iram_pkg::FUNC_WBYTE: begin
                if (st_reg != ST_IDLE) held_next = {1'b1, q_data.wr_data};
            end
            iram_pkg::FUNC_TICK: begin
                if (st_reg == ST_IDLE) begin
                end else if (st_reg == ST_WR_WAIT) begin
                    if (held_reg[8]) begin
                        held_next = '0; shf_next = held_reg[7:0]; bit_next = '0;
                        role_next = ROLE_DATA; st_next = ST_TX_SETUP; pcnt_next = '0;
                    end
                end else if (st_reg == ST_SLV_POLL) begin
                    if (!q_data.sda_in) begin
                        pcnt_next = '0;
                        unique case (role_reg)
                            ROLE_ADDR_W: begin
                                shf_next = wide_reg ? rega_reg[15:8] : rega_reg[7:0];
                                role_next = wide_reg ? ROLE_REG_HI : ROLE_REG_LO;
                                bit_next = '0; st_next = ST_TX_SETUP;
                            end
                            ROLE_REG_HI: begin
                                shf_next = rega_reg[7:0]; role_next = ROLE_REG_LO;
                                bit_next = '0; st_next = ST_TX_SETUP;
                            end
                            ROLE_REG_LO: begin
                                if (rd_reg) begin
                                    role_next = ROLE_ADDR_R; st_next = ST_START_HI;
                                end else if (left_reg == 8'd0) begin
                                    ends_next = iram_pkg::STATUS_OK; st_next = ST_STOP_LO;
                                end else begin
                                    st_next = ST_WR_WAIT;
                                end
                            end
                            ROLE_DATA: begin
                                left_next = left_reg - 8'd1;
                                if (left_reg == 8'd1) begin
                                    ends_next = iram_pkg::STATUS_OK; st_next = ST_STOP_LO;
                                end else begin
                                    st_next = ST_WR_WAIT;
                                end
                            end
                            default: begin
                                bit_next = '0; shf_next = '0; st_next = ST_RX_LOW;
                            end
                        endcase
                    end else if (ackw_reg >= cfg.ack_timeout) begin
                        ends_next = iram_pkg::STATUS_NO_ACK;
                        st_next = ST_STOP_LO; pcnt_next = '0;
                    end else begin
                        ackw_next = ackw_reg + 20'd1;
                    end
                end else if (pcnt_reg == 16'd0 && st_reg == ST_START_HI && !q_data.sda_in) begin
                    ends_next = iram_pkg::STATUS_BUS_ERR; st_next = ST_STOP_LO; pcnt_next = '0;
                end else if (pcnt_reg == 16'd0 && st_reg == ST_START_LO && q_data.sda_in) begin
                    ends_next = iram_pkg::STATUS_BUS_ERR; st_next = ST_STOP_LO; pcnt_next = '0;
                end else begin
                    if (pcnt_reg == 16'd0 && st_reg == ST_RX_HIGH)
                        shf_next = {shf_reg[6:0], q_data.sda_in};
                    pcnt_next = pinc;
                    if (pinc >= plen) begin
                        pcnt_next = '0;
                        unique case (st_reg)
                            ST_START_HI: st_next = ST_START_LO;
                            ST_START_LO: begin
                                shf_next = (role_reg == ROLE_ADDR_R) ? dev_reg + 8'd1 : dev_reg;
                                bit_next = '0; st_next = ST_TX_SETUP;
                            end
                            ST_TX_SETUP: st_next = ST_TX_HIGH;
                            ST_TX_HIGH:  st_next = ST_TX_LOW;
                            ST_TX_LOW: begin
                                bit_next = binc;
                                st_next = (binc >= 4'd8) ? ST_SLV_REL : ST_TX_SETUP;
                            end
                            ST_SLV_REL: st_next = ST_SLV_CLK;
                            ST_SLV_CLK: begin
                                ackw_next = '0; st_next = ST_SLV_POLL;
                            end
                            ST_RX_LOW: st_next = ST_RX_HIGH;
                            ST_RX_HIGH: begin
                                bit_next = binc;
                                st_next = (binc >= 4'd8) ? ST_MA_LOW : ST_RX_LOW;
                            end
                            ST_MA_LOW: st_next = ST_MA_HIGH;
                            ST_MA_HIGH: begin
                                res.rd_valid = 1'b1;
                                res.rd_data  = shf_next;
                                res.rd_last  = (left_reg <= 8'd1);
                                left_next = (left_reg == 8'd0) ? 8'd0 : left_reg - 8'd1;
                                if (left_reg <= 8'd1) begin
                                    ends_next = iram_pkg::STATUS_OK; st_next = ST_STOP_LO;
                                end else begin
                                    bit_next = '0; shf_next = '0; st_next = ST_RX_LOW;
                                end
                            end
                            ST_STOP_LO: st_next = ST_STOP_HI;
                            ST_STOP_HI: begin
                                res.done_res = 1'b1; res.status = ends_reg;
                                st_next = ST_IDLE;
                            end
                            default: st_next = ST_IDLE;
                        endcase
                    end
                end
            end
            default: begin
            end
        endcase

        // line levels after the item
        m_bit = (left_next <= 8'd1);
        res.scl_out = 1'b1;
        res.sda_out = 1'b1;
        unique case (st_next)
            ST_START_LO: res.sda_out = 1'b0;
            ST_TX_SETUP, ST_TX_LOW: begin
                res.scl_out = 1'b0; res.sda_out = shf_next[3'd7 - bit_next[2:0]];
            end
            ST_TX_HIGH: res.sda_out = shf_next[3'd7 - bit_next[2:0]];
            ST_SLV_REL, ST_WR_WAIT, ST_RX_LOW: res.scl_out = 1'b0;
            ST_MA_LOW: begin
                res.scl_out = 1'b0; res.sda_out = m_bit;
            end
            ST_MA_HIGH: res.sda_out = m_bit;
            ST_STOP_LO: begin
                res.scl_out = 1'b0; res.sda_out = 1'b0;
            end
            default: begin
            end
        endcase
        res.wr_request = (st_next == ST_WR_WAIT) && !held_next[8];
        res.busy_res   = (st_next != ST_IDLE);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg <= ST_IDLE; pcnt_reg <= '0; bit_reg <= '0; shf_reg <= '0;
            left_reg <= '0; ackw_reg <= '0; dev_reg <= '0; rega_reg <= '0;
            wide_reg <= 1'b0; rd_reg <= 1'b0; held_reg <= '0;
            role_reg <= ROLE_ADDR_W; ends_reg <= iram_pkg::STATUS_OK;
        end else if (step) begin
            st_reg <= st_next; pcnt_reg <= pcnt_next; bit_reg <= bit_next;
            shf_reg <= shf_next; left_reg <= left_next; ackw_reg <= ackw_next;
            dev_reg <= dev_next; rega_reg <= rega_next; wide_reg <= wide_next;
            rd_reg <= rd_next; held_reg <= held_next; role_reg <= role_next;
            ends_reg <= ends_next;
        end
    end

    // output stage with skid entry
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
        end else begin
            if (!v0_reg || m_ready) begin
                if (v1_reg) begin
                    o0_reg <= o1_reg; v0_reg <= 1'b1; v1_reg <= step;
                    if (step) o1_reg <= res;
                end else begin
                    v0_reg <= step;
                    if (step) o0_reg <= res;
                end
            end else if (step) begin
                o1_reg <= res; v1_reg <= 1'b1;
            end
        end
    end
endmodule
`default_nettype wire

// ===== hdl/iram_cfg.sv =====
// configuration register file
`default_nettype none
module iram_cfg (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [19:0] cfg_data,
    output iram_pkg::cfg_t   cfg
);
    iram_pkg::cfg_t cfg_reg;
    assign cfg_ready = 1'b1;
    assign cfg = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.data_phase_ticks <= iram_pkg::DATA_PHASE_RST;
            cfg_reg.ctrl_phase_ticks <= iram_pkg::CTRL_PHASE_RST;
            cfg_reg.ack_timeout      <= iram_pkg::ACK_TMO_RST;
        end else if (cfg_valid) begin
            if (cfg_index == iram_pkg::CFG_DATA_PHASE)
                cfg_reg.data_phase_ticks <= cfg_data[15:0];
            if (cfg_index == iram_pkg::CFG_CTRL_PHASE)
                cfg_reg.ctrl_phase_ticks <= cfg_data[15:0];
            if (cfg_index == iram_pkg::CFG_ACK_TMO)
                cfg_reg.ack_timeout <= cfg_data;
        end
    end
endmodule
`default_nettype wire

// ===== hdl/i2c_register_access_master.sv =====
// Register-access I2C master. Every accepted input transfer (tick, begin, write byte or
// the unused function code) yields exactly one result transfer with the line levels and
// status after it. Throughput is one item per clock while the result side is not stalled:
// a two-entry input queue feeds the bus sequencer, which writes each item's result into an
// output register with a skid entry. A stalled result side holds the input off once the
// skid entry and the queue are full. Bus timing follows the tick items, not aclk.
`default_nettype none
module i2c_register_access_master (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_valid,
    output logic                     s_ready,
    input  wire iram_pkg::in_item_t  s_data,
    output logic                     m_valid,
    input  wire logic                m_ready,
    output iram_pkg::out_item_t      m_data,
    input  wire logic                cfg_valid,
    output logic                     cfg_ready,
    input  wire logic [1:0]          cfg_index,
    input  wire logic [19:0]         cfg_data
);
    iram_pkg::in_item_t q_data;
    iram_pkg::cfg_t     cfg;
    logic q_valid, q_ready;

    iram_cfg u_cfg (
        .aclk, .aresetn, .cfg_valid, .cfg_ready, .cfg_index, .cfg_data, .cfg
    );
    iram_front u_front (
        .aclk, .aresetn, .s_valid, .s_ready, .s_data, .q_valid, .q_ready, .q_data
    );
    iram_engine u_engine (
        .aclk, .aresetn, .cfg, .q_valid, .q_ready, .q_data,
        .m_valid, .m_ready, .m_data
    );
endmodule
`default_nettype wire

// ===== hdl/iram_checker.sv =====
// port-level checks for the i2c register access master
`default_nettype none
`include "i2c_register_access_master_defines.svh"
module iram_checker (
    input wire logic                aclk,
    input wire logic                aresetn,
    input wire logic                m_valid,
    input wire logic                m_ready,
    input wire iram_pkg::out_item_t m_data
);
    `IRAM_ASSERT_NEXT(a_m_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_data))
    `IRAM_ASSERT_SAME(a_done_idle, aclk, aresetn, m_valid && m_data.done_res, !m_data.busy_res)
    `IRAM_ASSERT_SAME(a_rd_busy, aclk, aresetn, m_valid && m_data.rd_valid, m_data.busy_res)
    `IRAM_ASSERT_SAME(a_req_scl, aclk, aresetn, m_valid && m_data.wr_request, !m_data.scl_out)
endmodule

bind i2c_register_access_master iram_checker u_chk (
    .aclk, .aresetn, .m_valid, .m_ready, .m_data
);
`default_nettype wire

// ===== tb/testbench.sv =====
// self-checking testbench for the i2c register access master with predictor and scoreboard
module testbench;
    localparam logic [1:0] FUNC_NOP = 2'd3;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int HOLD_CYCLES = 400;
    localparam int PHASE_ITEMS = 220;

    typedef enum logic [4:0] {
        PH_IDLE, PH_START_HI, PH_START_LO, PH_TX_SETUP, PH_TX_HIGH, PH_TX_LOW,
        PH_SLV_REL, PH_SLV_CLK, PH_SLV_POLL, PH_WR_WAIT, PH_RX_LOW, PH_RX_HIGH,
        PH_MA_LOW, PH_MA_HIGH, PH_STOP_LO, PH_STOP_HI
    } bus_phase_e;

    typedef enum logic [2:0] {
        BYTE_ADDR_W, BYTE_REG_HI, BYTE_REG_LO, BYTE_DATA, BYTE_ADDR_R
    } byte_kind_e;

    typedef struct {
        iram_pkg::in_item_t  it;
        int                  reps;
        bit                  typed;
        iram_pkg::out_item_t want;
    } stim_row_t;

    logic                aclk = 1'b0;
    logic                aresetn = 1'b0;
    logic                s_valid = 1'b0;
    logic                s_ready;
    iram_pkg::in_item_t  s_data = '0;
    logic                m_valid;
    logic                m_ready = 1'b0;
    iram_pkg::out_item_t m_data;
    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    logic [1:0]          cfg_index = iram_pkg::CFG_DATA_PHASE;
    logic [19:0]         cfg_data = '0;

    // bus sequencer mirror
    bus_phase_e  ph;
    byte_kind_e  kind;
    logic [15:0] ph_cnt, dph, cph;
    logic [3:0]  bit_idx;
    logic [7:0]  shreg, left, cmd_dev, held_b;
    logic [15:0] cmd_reg;
    logic        cmd_wide, cmd_rd, held_v;
    logic [19:0] ack_cnt, ack_lim;
    logic [1:0]  end_st;

    iram_pkg::out_item_t line_results_q[$];
    stim_row_t   rows[$];
    int          mismatches = 0;
    int          counted = 0;
    int          ack_pct = 90;
    int          idle_cycles = 0;
    bit          quiet = 1'b0;
    bit          hold_req = 1'b0;

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    i2c_register_access_master DUT (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    function automatic void enter_ph(bus_phase_e p);
        ph = p;
        ph_cnt = '0;
    endfunction

    function automatic void stop_with(logic [1:0] s);
        end_st = s;
        enter_ph(PH_STOP_LO);
    endfunction

    function automatic void send_byte(logic [7:0] b, byte_kind_e k);
        shreg = b;
        bit_idx = '0;
        kind = k;
        enter_ph(PH_TX_SETUP);
    endfunction

    function automatic logic [15:0] phase_ticks(bus_phase_e p);
        case (p)
            PH_START_HI, PH_START_LO, PH_MA_LOW, PH_MA_HIGH, PH_STOP_LO, PH_STOP_HI: return cph;
            PH_TX_SETUP, PH_TX_HIGH, PH_TX_LOW, PH_RX_LOW, PH_RX_HIGH: return dph;
            default: return 16'd1;
        endcase
    endfunction

    function automatic void slave_acked();
        case (kind)
            BYTE_ADDR_W: begin
                if (cmd_wide) send_byte(cmd_reg[15:8], BYTE_REG_HI);
                else send_byte(cmd_reg[7:0], BYTE_REG_LO);
            end
            BYTE_REG_HI: send_byte(cmd_reg[7:0], BYTE_REG_LO);
            BYTE_REG_LO: begin
                if (cmd_rd) begin
                    kind = BYTE_ADDR_R;
                    enter_ph(PH_START_HI);
                end else if (left == 0) stop_with(iram_pkg::STATUS_OK);
                else enter_ph(PH_WR_WAIT);
            end
            BYTE_DATA: begin
                left = left - 8'd1;
                if (left == 0) stop_with(iram_pkg::STATUS_OK);
                else enter_ph(PH_WR_WAIT);
            end
            default: begin
                bit_idx = '0;
                shreg = '0;
                enter_ph(PH_RX_LOW);
            end
        endcase
    endfunction

    function automatic iram_pkg::out_item_t bus_tick(logic sda);
        iram_pkg::out_item_t o;
        o = '0;
        if (ph == PH_IDLE) return o;
        if (ph == PH_WR_WAIT) begin
            if (held_v) begin
                held_v = 1'b0;
                send_byte(held_b, BYTE_DATA);
            end
            return o;
        end
        if (ph == PH_SLV_POLL) begin
            if (!sda) slave_acked();
            else if (ack_cnt >= ack_lim) stop_with(iram_pkg::STATUS_NO_ACK);
            else ack_cnt++;
            return o;
        end
        // start check and read sampling happen on the first tick of a phase
        if (ph_cnt == 0) begin
            if (ph == PH_START_HI && !sda) begin
                stop_with(iram_pkg::STATUS_BUS_ERR);
                return o;
            end
            if (ph == PH_START_LO && sda) begin
                stop_with(iram_pkg::STATUS_BUS_ERR);
                return o;
            end
            if (ph == PH_RX_HIGH) shreg = {shreg[6:0], sda};
        end
        ph_cnt++;
        if (ph_cnt < phase_ticks(ph)) return o;
        case (ph)
            PH_START_HI: enter_ph(PH_START_LO);
            PH_START_LO: send_byte(kind == BYTE_ADDR_R ? cmd_dev + 8'd1 : cmd_dev, kind);
            PH_TX_SETUP: enter_ph(PH_TX_HIGH);
            PH_TX_HIGH: enter_ph(PH_TX_LOW);
            PH_TX_LOW: begin
                bit_idx++;
                enter_ph(bit_idx >= 8 ? PH_SLV_REL : PH_TX_SETUP);
            end
            PH_SLV_REL: enter_ph(PH_SLV_CLK);
            PH_SLV_CLK: begin
                ack_cnt = '0;
                enter_ph(PH_SLV_POLL);
            end
            PH_RX_LOW: enter_ph(PH_RX_HIGH);
            PH_RX_HIGH: begin
                bit_idx++;
                enter_ph(bit_idx >= 8 ? PH_MA_LOW : PH_RX_LOW);
            end
            PH_MA_LOW: enter_ph(PH_MA_HIGH);
            PH_MA_HIGH: begin
                o.rd_valid = 1'b1;
                o.rd_data = shreg;
                o.rd_last = left <= 1;
                left = (left == 0) ? 8'd0 : left - 8'd1;
                if (left == 0) stop_with(iram_pkg::STATUS_OK);
                else begin
                    bit_idx = '0;
                    shreg = '0;
                    enter_ph(PH_RX_LOW);
                end
            end
            PH_STOP_LO: enter_ph(PH_STOP_HI);
            default: begin
                o.done_res = 1'b1;
                o.status = end_st;
                enter_ph(PH_IDLE);
            end
        endcase
        return o;
    endfunction

    function automatic iram_pkg::out_item_t predict_result(iram_pkg::in_item_t it);
        iram_pkg::out_item_t o;
        o = '0;
        case (it.func)
            iram_pkg::FUNC_BEGIN: begin
                if (ph == PH_IDLE) begin
                    cmd_dev = it.dev_addr;
                    cmd_reg = it.reg_addr;
                    cmd_wide = it.reg_wide;
                    cmd_rd = it.is_read;
                    left = it.xfer_length;
                    if (cmd_rd && left == 0) left = 8'd1;
                    held_v = 1'b0;
                    held_b = '0;
                    end_st = iram_pkg::STATUS_OK;
                    kind = BYTE_ADDR_W;
                    enter_ph(PH_START_HI);
                end
            end
            iram_pkg::FUNC_WBYTE: begin
                if (ph != PH_IDLE) begin
                    held_v = 1'b1;
                    held_b = it.wr_data;
                end
            end
            iram_pkg::FUNC_TICK: o = bus_tick(it.sda_in);
            default: ;
        endcase
        o.scl_out = 1'b1;
        o.sda_out = 1'b1;
        case (ph)
            PH_START_LO: o.sda_out = 1'b0;
            PH_TX_SETUP, PH_TX_LOW: begin
                o.scl_out = 1'b0;
                o.sda_out = shreg[3'd7 - bit_idx[2:0]];
            end
            PH_TX_HIGH: o.sda_out = shreg[3'd7 - bit_idx[2:0]];
            PH_SLV_REL, PH_WR_WAIT, PH_RX_LOW: o.scl_out = 1'b0;
            PH_MA_LOW: begin
                o.scl_out = 1'b0;
                o.sda_out = left <= 1;
            end
            PH_MA_HIGH: o.sda_out = left <= 1;
            PH_STOP_LO: begin
                o.scl_out = 1'b0;
                o.sda_out = 1'b0;
            end
            default: ;
        endcase
        o.wr_request = (ph == PH_WR_WAIT) && !held_v;
        o.busy_res = ph != PH_IDLE;
        return o;
    endfunction

    function automatic void reset_model();
        dph = iram_pkg::DATA_PHASE_RST;
        cph = iram_pkg::CTRL_PHASE_RST;
        ack_lim = iram_pkg::ACK_TMO_RST;
        enter_ph(PH_IDLE);
        kind = BYTE_ADDR_W;
        bit_idx = '0;
        shreg = '0;
        left = '0;
        ack_cnt = '0;
        cmd_dev = '0;
        cmd_reg = '0;
        cmd_wide = 1'b0;
        cmd_rd = 1'b0;
        held_v = 1'b0;
        held_b = '0;
        end_st = iram_pkg::STATUS_OK;
    endfunction

    // slave side behaviour: mostly clean start levels and mostly acked bytes
    function automatic logic pick_sda();
        if (ph == PH_START_HI && ph_cnt == 0) return $urandom_range(0, 19) != 0;
        if (ph == PH_START_LO && ph_cnt == 0) return $urandom_range(0, 19) == 0;
        if (ph == PH_SLV_POLL) return $urandom_range(0, 99) >= ack_pct;
        return 1'($urandom_range(0, 1));
    endfunction

    function automatic iram_pkg::in_item_t next_stim();
        iram_pkg::in_item_t it;
        logic [63:0] rnd;
        int r;
        rnd = {$urandom, $urandom};
        it = rnd[$bits(iram_pkg::in_item_t)-1:0];
        r = $urandom_range(0, 99);
        it.func = iram_pkg::FUNC_TICK;
        it.sda_in = pick_sda();
        if (ph == PH_IDLE) begin
            if (r < 75) begin
                it.func = iram_pkg::FUNC_BEGIN;
                if ($urandom_range(0, 59) == 0) it.xfer_length = 8'($urandom_range(4, 24));
                else it.xfer_length = 8'($urandom_range(0, 3));
            end else if (r < 85) it.func = FUNC_NOP;
            else if (r < 92) it.func = iram_pkg::FUNC_WBYTE;
        end else if (ph == PH_WR_WAIT && !held_v) begin
            if (r < 85) it.func = iram_pkg::FUNC_WBYTE;
        end else if (r < 2) it.func = iram_pkg::FUNC_WBYTE;
        else if (r == 2) it.func = FUNC_NOP;
        else if (r == 3) it.func = iram_pkg::FUNC_BEGIN;
        return it;
    endfunction

    function automatic iram_pkg::in_item_t mk_in(logic [1:0] f, logic [7:0] dev,
                                                 logic [15:0] ra, logic wide, logic rd,
                                                 logic [7:0] len, logic sda);
        iram_pkg::in_item_t it;
        it = '0;
        it.func = f;
        it.dev_addr = dev;
        it.reg_addr = ra;
        it.reg_wide = wide;
        it.is_read = rd;
        it.xfer_length = len;
        it.wr_data = 8'hFF;
        it.sda_in = sda;
        return it;
    endfunction

    function automatic iram_pkg::out_item_t mk_out(logic scl, logic sda, logic busy,
                                                   logic done, logic [1:0] st);
        iram_pkg::out_item_t o;
        o = '0;
        o.scl_out = scl;
        o.sda_out = sda;
        o.busy_res = busy;
        o.done_res = done;
        o.status = st;
        return o;
    endfunction

    function automatic void add_row(iram_pkg::in_item_t it, int reps, bit typed,
                                    iram_pkg::out_item_t want);
        stim_row_t r;
        r.it = it;
        r.reps = reps;
        r.typed = typed;
        r.want = want;
        rows.push_back(r);
    endfunction

    task automatic drive_item(iram_pkg::in_item_t it, bit typed, iram_pkg::out_item_t want);
        iram_pkg::out_item_t got;
        bus_phase_e was;
        if (!quiet && $urandom_range(0, 15) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= it;
        do @(posedge aclk); while (!s_ready);
        was = ph;
        got = predict_result(it);
        line_results_q.push_back(typed ? want : got);
        if (was != PH_IDLE || it.func == iram_pkg::FUNC_BEGIN) counted++;
    endtask

    task automatic settle();
        s_valid <= 1'b0;
        while (line_results_q.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic write_regs(logic [15:0] d, logic [15:0] c, logic [19:0] a);
        logic [19:0] vals[3];
        vals[0] = {4'd0, d};
        vals[1] = {4'd0, c};
        vals[2] = a;
        for (int i = 0; i < 3; i++) begin
            cfg_valid <= 1'b1;
            cfg_index <= 2'(i);
            cfg_data <= vals[i];
            do @(posedge aclk); while (!cfg_ready);
        end
        cfg_valid <= 1'b0;
        dph = d;
        cph = c;
        ack_lim = a;
    endtask

    task automatic run_phase(int n);
        counted = 0;
        while (counted < n || ph != PH_IDLE) drive_item(next_stim(), 1'b0, '0);
        settle();
    endtask

    // result side: scoreboard and stalls
    initial begin
        iram_pkg::out_item_t want;
        bit bad;
        wait (aresetn);
        m_ready <= 1'b1;
        forever begin
            @(posedge aclk);
            if (m_valid && m_ready) begin
                if (line_results_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) $display("unexpected result transfer %p", m_data);
                end else begin
                    want = line_results_q.pop_front();
                    bad = want.scl_out !== m_data.scl_out || want.sda_out !== m_data.sda_out
                       || want.rd_valid !== m_data.rd_valid || want.rd_data !== m_data.rd_data
                       || want.rd_last !== m_data.rd_last
                       || want.wr_request !== m_data.wr_request
                       || want.busy_res !== m_data.busy_res
                       || want.done_res !== m_data.done_res || want.status !== m_data.status;
                    if (bad) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: expected %p got %p", want, m_data);
                    end
                end
            end
            if (hold_req) begin
                hold_req = 1'b0;
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                m_ready <= 1'b1;
            end else if (!quiet && $urandom_range(0, 15) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 14)) @(posedge aclk);
                m_ready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready)) begin
                idle_cycles <= 0;
            end else if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("** i2c_register_access_master: FAILED **");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    initial begin
        logic [15:0] d_set[5];
        logic [15:0] c_set[5];
        logic [19:0] a_set[5];
        int pct_set[5];
        iram_pkg::out_item_t idle_out;
        d_set = '{16'd1, 16'd2, 16'd0, 16'd3, 16'd1};
        c_set = '{16'd1, 16'd1, 16'd0, 16'd2, 16'd3};
        a_set = '{20'd3, 20'd0, 20'd1, 20'hFFFFF, 20'd2};
        pct_set = '{90, 70, 80, 95, 75};
        idle_out = mk_out(1'b1, 1'b1, 1'b0, 1'b0, iram_pkg::STATUS_OK);
        reset_model();

        // idle noise, bus error at start high, then at start low
        add_row(mk_in(iram_pkg::FUNC_TICK, 8'h00, 16'h0000, 1'b0, 1'b0, 8'd0, 1'b0), 1, 1'b1,
                idle_out);
        add_row(mk_in(FUNC_NOP, 8'hFF, 16'hFFFF, 1'b1, 1'b1, 8'hFF, 1'b1), 1, 1'b1, idle_out);
        add_row(mk_in(iram_pkg::FUNC_WBYTE, 8'h00, 16'h0000, 1'b0, 1'b0, 8'd0, 1'b0), 1, 1'b1,
                idle_out);
        add_row(mk_in(iram_pkg::FUNC_BEGIN, 8'hFF, 16'hFFFF, 1'b1, 1'b0, 8'hFF, 1'b1), 1, 1'b1,
                mk_out(1'b1, 1'b1, 1'b1, 1'b0, iram_pkg::STATUS_OK));
        add_row(mk_in(iram_pkg::FUNC_BEGIN, 8'h00, 16'h0000, 1'b0, 1'b1, 8'd0, 1'b0), 1, 1'b0,
                '0);
        add_row(mk_in(iram_pkg::FUNC_TICK, 8'h00, 16'h0000, 1'b0, 1'b0, 8'd0, 1'b0), 1, 1'b1,
                mk_out(1'b0, 1'b0, 1'b1, 1'b0, iram_pkg::STATUS_OK));
        add_row(mk_in(iram_pkg::FUNC_TICK, 8'h00, 16'h0000, 1'b0, 1'b0, 8'd0, 1'b1), 9, 1'b0,
                '0);
        add_row(mk_in(iram_pkg::FUNC_TICK, 8'h00, 16'h0000, 1'b0, 1'b0, 8'd0, 1'b1), 1, 1'b1,
                mk_out(1'b1, 1'b1, 1'b0, 1'b1, iram_pkg::STATUS_BUS_ERR));
        add_row(mk_in(iram_pkg::FUNC_BEGIN, 8'hFF, 16'h0000, 1'b0, 1'b1, 8'd0, 1'b1), 1, 1'b0,
                '0);
        add_row(mk_in(iram_pkg::FUNC_TICK, 8'h00, 16'h0000, 1'b0, 1'b0, 8'd0, 1'b1), 5, 1'b0,
                '0);
        add_row(mk_in(iram_pkg::FUNC_TICK, 8'h00, 16'h0000, 1'b0, 1'b0, 8'd0, 1'b1), 1, 1'b1,
                mk_out(1'b0, 1'b0, 1'b1, 1'b0, iram_pkg::STATUS_OK));
        add_row(mk_in(iram_pkg::FUNC_TICK, 8'h00, 16'h0000, 1'b0, 1'b0, 8'd0, 1'b0), 9, 1'b0,
                '0);
        add_row(mk_in(iram_pkg::FUNC_TICK, 8'h00, 16'h0000, 1'b0, 1'b0, 8'd0, 1'b1), 1, 1'b1,
                mk_out(1'b1, 1'b1, 1'b0, 1'b1, iram_pkg::STATUS_BUS_ERR));

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (rows[i])
            for (int k = 0; k < rows[i].reps; k++)
                drive_item(rows[i].it, rows[i].typed, rows[i].want);
        settle();

        for (int i = 0; i < 5; i++) begin
            write_regs(d_set[i], c_set[i], a_set[i]);
            ack_pct = pct_set[i];
            if (i == 3) hold_req = 1'b1;
            run_phase(PHASE_ITEMS);
        end

        // widest data phase setting, then a start error and a long stop
        write_regs(16'hFFFF, 16'd100, 20'd5);
        drive_item(mk_in(iram_pkg::FUNC_BEGIN, 8'h5A, 16'hA5A5, 1'b1, 1'b0, 8'd1, 1'b1),
                   1'b0, '0);
        drive_item(mk_in(iram_pkg::FUNC_TICK, 8'h00, 16'h0000, 1'b0, 1'b0, 8'd0, 1'b0),
                   1'b0, '0);
        run_phase(0);

        quiet = 1'b1;
        write_regs(16'd1, 16'd1, 20'd4);
        ack_pct = 85;
        run_phase(PHASE_ITEMS);

        if (mismatches == 0) begin
            $display("** i2c_register_access_master: PASSED **");
        end else begin
            $display("** i2c_register_access_master: FAILED **");
        end
        $finish;
    end
endmodule

// ===== sim.f =====
+incdir+hdl
hdl/iram_pkg.sv
hdl/iram_front.sv
hdl/iram_engine.sv
hdl/iram_cfg.sv
hdl/i2c_register_access_master.sv
hdl/iram_checker.sv
tb/testbench.sv
